### src/fbm_pkg.sv
// Shared types and constants for the file block mapper.
package fbm_pkg;

  localparam int OFF_W        = 14;
  localparam int N_DIRECT     = 5;
  localparam int START_BLOCK  = 3;
  localparam int SLOTS        = N_DIRECT + 2;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_UNALLOCATED = 2'd1;
  localparam logic [1:0] ST_NO_FREE     = 2'd2;
  localparam logic [1:0] ST_TOO_FAR     = 2'd3;

  typedef enum logic [1:0] {
    PASS_FILE = 2'd0,
    PASS_OFF  = 2'd1,
    PASS_DBL  = 2'd2
  } div_pass_t;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_DIV   = 11'b00000000010,
    S_CLASS = 11'b00000000100,
    S_FPRD  = 11'b00000001000,
    S_PERD  = 11'b00000010000,
    S_CHK   = 11'b00000100000,
    S_CLR   = 11'b00001000000,
    S_PADR  = 11'b00010000000,
    S_DADR  = 11'b00100000000,
    S_DRW   = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

endpackage

### src/fbm_if.sv
// Valid/ready channel interfaces for access requests and results.
interface fbm_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [4:0]  file_index;
  logic [13:0] byte_offset;
  logic [7:0]  write_byte;
  modport source (output valid, operation, file_index, byte_offset, write_byte, input ready);
  modport sink   (input valid, operation, file_index, byte_offset, write_byte, output ready);
endinterface

interface fbm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;
  logic [1:0] status;
  modport source (output valid, read_byte, status, input ready);
  modport sink   (input valid, read_byte, status, output ready);
endinterface

### src/file_block_mapper.sv
// File block mapper: byte access through direct, single and double indirect pointers.
//
// in_ch carries one byte access (read or write) per transaction: operation, file
// index, byte offset and the byte to write. out_ch returns one transaction per
// access with the read byte and a status. cfg_we/cfg_wdata set last_block, the
// highest block number the free counter may hand out; write it only while idle.
//
// One access is handled at a time. A shared multiplier splits values by constant
// divisors through a reciprocal multiply: first the quotient, then the remainder.
// Two such passes (file index mod NUM_FILES, offset by data bytes per block) and, in
// the double-indirect range, a third for the pointer split come first; then the file
// pointer is read and checked, each further pointer level is addressed, read and
// checked, and the data byte is addressed and accessed. Each new pointer block is
// cleared entry by entry. in_ch is ready only in the idle state; the result sits
// in the output register until out_ch takes it, and a stalled receiver holds the
// block there.
//
// Reset clears all file pointers, sets the free counter to 3 and last_block to 255.
// Pointer and data memories are not cleared; pointer blocks are cleared as they
// are allocated.
module file_block_mapper
  import fbm_pkg::*;
#(
  parameter int NUM_FILES   = 32,
  parameter int NUM_BLOCKS  = 256,
  parameter int BLOCK_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  fbm_in_if.sink     in_ch,
  fbm_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  localparam int DPB      = BLOCK_BYTES - 4;
  localparam int PPB      = DPB / 4;
  localparam int DIR_LIM  = N_DIRECT;
  localparam int SGL_LIM  = N_DIRECT + PPB;
  localparam int DBL_LIM  = SGL_LIM + PPB * PPB;
  localparam int BLK_W    = $clog2(NUM_BLOCKS);
  localparam int NF_W     = BLK_W + 1;
  localparam int LW       = (NF_W > 8) ? NF_W : 8;
  localparam int FW       = (NUM_FILES > 1) ? $clog2(NUM_FILES) : 1;
  localparam int RW_A     = $clog2(BLOCK_BYTES);
  localparam int RW_B     = $clog2(NUM_FILES + 1);
  localparam int RW       = (RW_A > RW_B) ? RW_A : RW_B;
  localparam int PW       = $clog2(PPB);
  localparam int SW       = $clog2(SLOTS);
  localparam int FP_N     = NUM_FILES * SLOTS;
  localparam int PE_N     = NUM_BLOCKS * PPB;
  localparam int D_N      = NUM_BLOCKS * DPB;
  localparam int FPA_W    = $clog2(FP_N);
  localparam int PEA_W    = $clog2(PE_N);
  localparam int DA_W     = $clog2(D_N);
  // reciprocals rounded up; exact for every OFF_W-bit dividend
  localparam int DIV_K    = OFF_W + RW;
  localparam int MB_W     = DIV_K + 1;
  localparam int PR_W     = OFF_W + MB_W;
  localparam int RCP_F    = ((1 << DIV_K) + NUM_FILES - 1) / NUM_FILES;
  localparam int RCP_D    = ((1 << DIV_K) + DPB - 1) / DPB;
  localparam int RCP_P    = ((1 << DIV_K) + PPB - 1) / PPB;

  // storage
  logic [BLK_W-1:0] fp_mem [FP_N];
  logic [BLK_W:0]   pe_mem [PE_N];
  logic [7:0]       d_mem  [D_N];

  // control
  state_t           state_r, state_nxt;
  logic [NF_W-1:0]  nfb_r;
  logic [7:0]       last_block_r;
  logic [FP_N-1:0]  fp_vld_r;

  // datapath
  logic             wr_r;
  logic [7:0]       wb_r;
  logic [OFF_W-1:0] off_r;
  logic [OFF_W-1:0] dvd_r;
  logic [OFF_W-1:0] quo_r;
  logic [RW-1:0]    dsr_r;
  logic [MB_W-1:0]  rcp_r;
  logic             dph_r;
  div_pass_t        pass_r;
  logic [FW-1:0]    f_r;
  logic [OFF_W-1:0] q_r;
  logic [RW-1:0]    boff_r;
  logic [PW-1:0]    i0_r, i1_r, idx_r;
  logic [1:0]       lvl_r;
  logic             at_file_r;
  logic [FPA_W-1:0] fp_addr_r;
  logic [PEA_W-1:0] pe_addr_r;
  logic [PEA_W-1:0] clr_addr_r;
  logic [PW-1:0]    clr_cnt_r;
  logic [DA_W-1:0]  d_addr_r;
  logic [BLK_W-1:0] fp_q_r;
  logic             fpv_q_r;
  logic [BLK_W:0]   pe_q_r;
  logic [BLK_W-1:0] cur_blk_r;
  logic [7:0]       out_read_byte_r;
  logic [1:0]       out_status_r;

  // shared multiplier: phase 0 dividend * reciprocal, phase 1 quotient * divisor
  logic [OFF_W-1:0] mul_a;
  logic [MB_W-1:0]  mul_b;
  logic [PR_W-1:0]  prod;
  logic [OFF_W-1:0] quo_nxt;
  logic [RW-1:0]    rem_nxt;
  logic             div_last;

  assign mul_a    = dph_r ? quo_r : dvd_r;
  assign mul_b    = dph_r ? MB_W'(dsr_r) : rcp_r;
  assign prod     = PR_W'(mul_a) * PR_W'(mul_b);
  assign quo_nxt  = prod[DIV_K +: OFF_W];
  assign rem_nxt  = RW'(dvd_r - prod[OFF_W-1:0]);
  assign div_last = dph_r;

  // offset classification
  logic [31:0] q_ext;
  logic        is_dir, is_sgl, is_dbl;
  logic [SW-1:0] slot;

  assign q_ext  = 32'(q_r);
  assign is_dir = q_ext < 32'(DIR_LIM);
  assign is_sgl = !is_dir && (q_ext < 32'(SGL_LIM));
  assign is_dbl = !is_dir && !is_sgl && (q_ext < 32'(DBL_LIM));
  assign slot   = is_dir ? SW'(q_r) : (is_sgl ? SW'(N_DIRECT) : SW'(N_DIRECT + 1));

  // pointer check
  logic [LW-1:0]    lim;
  logic             hit, full, alloc;
  logic [BLK_W-1:0] hblk;
  state_t           adv_state;

  assign lim   = (LW'(last_block_r) > LW'(NUM_BLOCKS - 1)) ? LW'(NUM_BLOCKS - 1)
                                                           : LW'(last_block_r);
  assign hit   = at_file_r ? fpv_q_r : pe_q_r[BLK_W];
  assign hblk  = at_file_r ? fp_q_r : pe_q_r[BLK_W-1:0];
  assign full  = LW'(nfb_r) > lim;
  assign alloc = !hit && wr_r && !full;
  assign adv_state = (lvl_r == 2'd0) ? S_DADR : S_PADR;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_ch.valid) state_nxt = S_DIV;
      S_DIV: begin
        if (div_last) begin
          case (pass_r)
            PASS_FILE: state_nxt = S_DIV;
            PASS_OFF:  state_nxt = S_CLASS;
            default:   state_nxt = S_FPRD;
          endcase
        end
      end
      S_CLASS: begin
        if (is_dir || is_sgl) state_nxt = S_FPRD;
        else if (is_dbl)      state_nxt = S_DIV;
        else                  state_nxt = S_OUT;
      end
      S_FPRD:  state_nxt = S_CHK;
      S_PERD:  state_nxt = S_CHK;
      S_CHK: begin
        if (hit)                   state_nxt = adv_state;
        else if (!alloc)           state_nxt = S_OUT;
        else if (lvl_r != 2'd0)    state_nxt = S_CLR;
        else                       state_nxt = adv_state;
      end
      S_CLR:   if (clr_cnt_r == PW'(PPB - 1)) state_nxt = adv_state;
      S_PADR:  state_nxt = S_PERD;
      S_DADR:  state_nxt = S_DRW;
      S_DRW:   state_nxt = S_OUT;
      S_OUT:   if (out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      nfb_r        <= NF_W'(START_BLOCK);
      last_block_r <= 8'd255;
      fp_vld_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) last_block_r <= cfg_wdata;
      if (state_r == S_CHK && alloc) begin
        nfb_r <= nfb_r + NF_W'(1);
        if (at_file_r) fp_vld_r[fp_addr_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        wr_r   <= in_ch.operation;
        wb_r   <= in_ch.write_byte;
        off_r  <= in_ch.byte_offset;
        dvd_r  <= OFF_W'(in_ch.file_index);
        dsr_r  <= RW'(NUM_FILES);
        rcp_r  <= MB_W'(RCP_F);
        pass_r <= PASS_FILE;
        dph_r  <= 1'b0;
      end
      S_DIV: begin
        dph_r <= !dph_r;
        if (!div_last) begin
          quo_r <= quo_nxt;
        end else begin
          case (pass_r)
            PASS_FILE: begin
              f_r    <= FW'(rem_nxt);
              dvd_r  <= off_r;
              dsr_r  <= RW'(DPB);
              rcp_r  <= MB_W'(RCP_D);
              pass_r <= PASS_OFF;
            end
            PASS_OFF: begin
              q_r    <= quo_r;
              boff_r <= rem_nxt;
            end
            default: begin
              i0_r <= PW'(quo_r);
              i1_r <= PW'(rem_nxt);
            end
          endcase
        end
      end
      S_CLASS: begin
        fp_addr_r <= FPA_W'(f_r) * FPA_W'(SLOTS) + FPA_W'(slot);
        at_file_r <= 1'b1;
        lvl_r     <= is_dir ? 2'd0 : (is_sgl ? 2'd1 : 2'd2);
        if (is_sgl) i1_r <= PW'(q_ext - 32'(N_DIRECT));
        if (is_dbl) begin
          dvd_r  <= OFF_W'(q_ext - 32'(SGL_LIM));
          dsr_r  <= RW'(PPB);
          rcp_r  <= MB_W'(RCP_P);
          pass_r <= PASS_DBL;
          dph_r  <= 1'b0;
        end
        if (!is_dir && !is_sgl && !is_dbl) begin
          out_status_r    <= ST_TOO_FAR;
          out_read_byte_r <= '0;
        end
      end
      S_FPRD: begin
        fp_q_r  <= fp_mem[fp_addr_r];
        fpv_q_r <= fp_vld_r[fp_addr_r];
      end
      S_PERD: pe_q_r <= pe_mem[pe_addr_r];
      S_CHK: begin
        at_file_r <= 1'b0;
        if (hit) begin
          cur_blk_r <= hblk;
        end else if (alloc) begin
          cur_blk_r  <= BLK_W'(nfb_r);
          clr_addr_r <= PEA_W'(nfb_r) * PEA_W'(PPB);
          clr_cnt_r  <= '0;
          if (at_file_r) fp_mem[fp_addr_r] <= BLK_W'(nfb_r);
          else           pe_mem[pe_addr_r] <= {1'b1, BLK_W'(nfb_r)};
        end else begin
          out_status_r    <= wr_r ? ST_NO_FREE : ST_UNALLOCATED;
          out_read_byte_r <= '0;
        end
      end
      S_CLR: begin
        pe_mem[clr_addr_r] <= '0;
        clr_addr_r <= clr_addr_r + PEA_W'(1);
        clr_cnt_r  <= clr_cnt_r + PW'(1);
      end
      S_PADR: pe_addr_r <= PEA_W'(cur_blk_r) * PEA_W'(PPB) + PEA_W'(idx_r);
      S_DADR: d_addr_r  <= DA_W'(cur_blk_r) * DA_W'(DPB) + DA_W'(boff_r);
      S_DRW: begin
        out_status_r <= ST_OK;
        if (wr_r) begin
          d_mem[d_addr_r] <= wb_r;
          out_read_byte_r <= '0;
        end else begin
          out_read_byte_r <= d_mem[d_addr_r];
        end
      end
      default: ;
    endcase
    // step down one pointer level
    if ((state_r == S_CHK || state_r == S_CLR) && state_nxt == S_PADR) begin
      idx_r <= (lvl_r == 2'd2) ? i0_r : i1_r;
      lvl_r <= lvl_r - 2'd1;
    end
  end

  assign in_ch.ready      = state_r == S_IDLE;
  assign out_ch.valid     = state_r == S_OUT;
  assign out_ch.read_byte = out_read_byte_r;
  assign out_ch.status    = out_status_r;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready) else $error("request taken while result pending");

  a_free_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    nfb_r >= $past(nfb_r)) else $error("free block counter went backwards");

  a_clear_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLR |-> clr_cnt_r < PW'(PPB)) else $error("clear sweep overran block");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_status_r != ST_OK |-> out_read_byte_r == 8'd0)
    else $error("nonzero byte on failed access");

endmodule

### sim/file_block_mapper_tb.sv
// Self-checking testbench for file_block_mapper: directed and random byte accesses checked against a predictor.
module file_block_mapper_tb
  import fbm_pkg::*;
();

  localparam int NFILES    = 32;
  localparam int NBLK      = 256;
  localparam int DATA_B    = 60;
  localparam int PTRS      = 15;
  localparam int DIRECT_END = N_DIRECT * DATA_B;
  localparam int SINGLE_END = DIRECT_END + PTRS * DATA_B;
  localparam int DOUBLE_END = SINGLE_END + PTRS * PTRS * DATA_B;
  localparam bit OP_RD = 1'b0;
  localparam bit OP_WR = 1'b1;

  typedef struct packed {
    bit        op;
    bit [4:0]  file;
    bit [13:0] off;
    bit [7:0]  wbyte;
  } access_t;

  typedef struct packed {
    bit [7:0] rbyte;
    bit [1:0] status;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;

  fbm_in_if  in_ch ();
  fbm_out_if out_ch ();

  file_block_mapper u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // predictor state
  bit       fp_ok [NFILES*SLOTS];
  int       fp_blk[NFILES*SLOTS];
  bit       pe_ok [NBLK*PTRS];
  int       pe_blk[NBLK*PTRS];
  bit [7:0] mem_byte[NBLK*DATA_B];
  bit       mem_set [NBLK*DATA_B];
  int       free_ptr = START_BLOCK;
  int       last_blk = 255;

  access_t  pending[$];
  reply_t   expected_replies[$];
  access_t  written_addrs[$];
  int       send_idle = 0;
  int       recv_stall = 0;
  int       errors = 0;

  function automatic bit grab_block(output int blk);
    int lim;
    lim = (last_blk > NBLK - 1) ? NBLK - 1 : last_blk;
    if (free_ptr > lim) return 1'b0;
    blk = free_ptr;
    free_ptr++;
    return 1'b1;
  endfunction

  // Follow one link; in_file selects the file pointer table, else the pointer-entry store.
  function automatic logic [1:0] follow_link(bit in_file, int idx, bit wr, bit mkptr,
                                             inout int blk);
    int nb;
    if (in_file ? fp_ok[idx] : pe_ok[idx]) begin
      blk = in_file ? fp_blk[idx] : pe_blk[idx];
      return ST_OK;
    end
    if (!wr) return ST_UNALLOCATED;
    if (!grab_block(nb)) return ST_NO_FREE;
    if (in_file) begin
      fp_ok[idx] = 1'b1; fp_blk[idx] = nb;
    end else begin
      pe_ok[idx] = 1'b1; pe_blk[idx] = nb;
    end
    if (mkptr) begin
      for (int k = 0; k < PTRS; k++) pe_ok[nb*PTRS + k] = 1'b0;
    end
    blk = nb;
    return ST_OK;
  endfunction

  // Map and apply one access; unset is raised for a read of a never-written byte in an allocated block.
  function automatic reply_t map_access(access_t a, output bit unset);
    reply_t r;
    int o, slot, i0, i1, boff, lvl, blk;
    logic [1:0] st;
    r = '0;
    unset = 1'b0;
    o = int'(a.off);
    i0 = 0; i1 = 0; blk = 0;
    if (o < DIRECT_END) begin
      slot = o / DATA_B; boff = o % DATA_B; lvl = 0;
    end else if (o < SINGLE_END) begin
      o -= DIRECT_END;
      slot = N_DIRECT; i1 = o / DATA_B; boff = o % DATA_B; lvl = 1;
    end else if (o < DOUBLE_END) begin
      o -= SINGLE_END;
      slot = N_DIRECT + 1; i0 = o / (PTRS*DATA_B); o %= PTRS*DATA_B;
      i1 = o / DATA_B; boff = o % DATA_B; lvl = 2;
    end else begin
      r.status = ST_TOO_FAR;
      return r;
    end
    st = follow_link(1'b1, int'(a.file)*SLOTS + slot, a.op, lvl > 0, blk);
    if (st == ST_OK && lvl == 2) st = follow_link(1'b0, blk*PTRS + i0, a.op, 1'b1, blk);
    if (st == ST_OK && lvl >= 1) st = follow_link(1'b0, blk*PTRS + i1, a.op, 1'b0, blk);
    if (st != ST_OK) begin
      r.status = st;
      return r;
    end
    if (a.op == OP_WR) begin
      mem_byte[blk*DATA_B + boff] = a.wbyte;
      mem_set[blk*DATA_B + boff] = 1'b1;
    end else begin
      unset = !mem_set[blk*DATA_B + boff];
      r.rbyte = mem_byte[blk*DATA_B + boff];
    end
    r.status = ST_OK;
    return r;
  endfunction

  task automatic queue_access(access_t a);
    reply_t r;
    bit unset;
    r = map_access(a, unset);
    if (unset) begin
      // reading a never-written byte is outside the contract: store it instead
      a.op = OP_WR;
      r = map_access(a, unset);
    end
    if (a.op == OP_WR && r.status == ST_OK) written_addrs = {written_addrs, a};
    expected_replies = {expected_replies, r};
    pending = {pending, a};
  endtask

  function automatic access_t random_access();
    access_t a;
    int sel;
    a.op = 1'($urandom_range(1));
    a.file = ($urandom_range(3) != 0) ? 5'($urandom_range(3)) : 5'($urandom_range(31));
    a.wbyte = 8'($urandom_range(255));
    sel = int'($urandom_range(9));
    case (sel)
      0, 1, 2, 3: a.off = 14'($urandom_range(DIRECT_END - 1));
      4, 5:       a.off = 14'($urandom_range(SINGLE_END - 1, DIRECT_END));
      6, 7:       a.off = 14'($urandom_range(DOUBLE_END - 1, SINGLE_END));
      8:          a.off = 14'($urandom_range(16383, DOUBLE_END - 700));
      default:    a.off = 14'($urandom_range(16383));
    endcase
    // re-read stored bytes often so data paths get checked
    if (a.op == OP_RD && written_addrs.size() > 0 && $urandom_range(1) != 0) begin
      a = written_addrs[$urandom_range(written_addrs.size() - 1)];
      a.op = OP_RD;
    end
    return a;
  endfunction

  task automatic drain();
    while (pending.size() != 0 || in_ch.valid || expected_replies.size() != 0)
      @(posedge clk);
  endtask

  task automatic set_last_block(int v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v[7:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    last_blk = v;
  endtask

  task automatic random_phase(int n, int tx_idle, int rx_stall);
    send_idle = tx_idle;
    recv_stall = rx_stall;
    for (int k = 0; k < n; k++) queue_access(random_access());
  endtask

  // driver
  always @(posedge clk) begin
    access_t a;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.operation <= 1'b0;
      in_ch.file_index <= '0;
      in_ch.byte_offset <= '0;
      in_ch.write_byte <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending.size() != 0 && $urandom_range(99) >= send_idle) begin
        a = pending.pop_front();
        in_ch.operation <= a.op;
        in_ch.file_index <= a.file;
        in_ch.byte_offset <= a.off;
        in_ch.write_byte <= a.wbyte;
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    reply_t e;
    out_ch.ready <= rst_n && ($urandom_range(99) >= recv_stall);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_replies.size() == 0) begin
        $error("unexpected transaction: read_byte %0d status %0d",
               out_ch.read_byte, out_ch.status);
        errors++;
      end else begin
        e = expected_replies.pop_front();
        if (out_ch.read_byte !== e.rbyte) begin
          $error("read_byte expected %0d actual %0d", e.rbyte, out_ch.read_byte);
          errors++;
        end
        if (out_ch.status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, out_ch.status);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: tight pool so allocation runs out mid-walk
    set_last_block(4);
    queue_access('{OP_RD, 5'd0, 14'd0, 8'd0});
    queue_access('{OP_WR, 5'd0, 14'd0, 8'd255});
    queue_access('{OP_RD, 5'd0, 14'd0, 8'd0});
    queue_access('{OP_WR, 5'd0, 14'd300, 8'd17});   // pointer block taken, data block fails
    queue_access('{OP_RD, 5'd0, 14'd300, 8'd0});
    queue_access('{OP_WR, 5'd31, 14'd0, 8'd1});
    queue_access('{OP_WR, 5'd0, 14'd14700, 8'd9});
    queue_access('{OP_RD, 5'd31, 14'd16383, 8'd0});
    queue_access('{OP_WR, 5'd0, 14'd59, 8'd0});
    queue_access('{OP_RD, 5'd0, 14'd59, 8'd0});
    set_last_block(255);
    queue_access('{OP_WR, 5'd31, 14'd299, 8'd170});
    queue_access('{OP_RD, 5'd31, 14'd299, 8'd0});
    queue_access('{OP_WR, 5'd31, 14'd1199, 8'd85});
    queue_access('{OP_RD, 5'd31, 14'd1199, 8'd0});
    queue_access('{OP_WR, 5'd1, 14'd1200, 8'd200});
    queue_access('{OP_RD, 5'd1, 14'd1200, 8'd0});
    queue_access('{OP_WR, 5'd1, 14'd14699, 8'd255});
    queue_access('{OP_RD, 5'd1, 14'd14699, 8'd0});
    queue_access('{OP_RD, 5'd2, 14'd1200, 8'd0});
    queue_access('{OP_WR, 5'd2, 14'd16383, 8'd255});

    set_last_block(60);
    random_phase(400, 6, 66);
    set_last_block(150);
    random_phase(400, 66, 6);
    set_last_block(255);
    random_phase(450, 0, 0);
    set_last_block(4);
    random_phase(280, 6, 66);
    drain();
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("file_block_mapper test passed");
    end else begin
      $display("file_block_mapper test failed");
    end
    $finish;
  end

  initial begin
    #50000000;
    $display("file_block_mapper test failed");
    $finish;
  end

endmodule
